### src/chme_pkg.sv
package chme_pkg;

    localparam int CAPACITY   = 32;
    localparam int BUCKETS    = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 64;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int BKT_W  = $clog2(BUCKETS);

    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ABSENT = 2'd0,
        ST_HIT    = 2'd1,
        ST_NEW    = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

endpackage

### src/chme_ram.sv
module chme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/chained_hash_map_engine_core.sv
// Chained hash map: up to CAPACITY key/value entries kept densely in slots
// 0..count-1, with a bucket-head table indexed by the key's low bits and a
// next link per entry. One operation is taken at a time; in_stall stays high
// from acceptance until the result transfer completes. All tables sit in
// single-port-read RAMs with registered reads, so each chain step is a read
// issue followed by a compare. An erase that moves the last entry walks a
// second chain. No clearing pass after reset: bucket heads carry valid
// bits, and other stores are only read below the entry count.
module chained_hash_map_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [chme_pkg::KEY_BITS-1:0]     key,
    input  logic [chme_pkg::VALUE_BITS-1:0]   value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [chme_pkg::VALUE_BITS-1:0]   value_out,
    output logic [chme_pkg::SLOT_W-1:0]       entry_count
);

    localparam int IW = chme_pkg::IDX_W;
    localparam int SW = chme_pkg::SLOT_W;
    localparam int BW = chme_pkg::BKT_W;
    localparam int KW = chme_pkg::KEY_BITS;
    localparam int VW = chme_pkg::VALUE_BITS;
    localparam logic [SW-1:0] CAP = SW'(chme_pkg::CAPACITY);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HEAD  = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_CMP   = 9'b000001000,
        S_LK    = 9'b000010000,
        S_LHEAD = 9'b000100000,
        S_MV1   = 9'b001000000,
        S_MV2   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]    op_reg, op_next;
    logic [KW-1:0] key_reg, key_next;
    logic [VW-1:0] val_reg, val_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] hole_reg, hole_next;
    logic [KW-1:0] lk_reg, lk_next;
    logic [VW-1:0] lv_reg, lv_next;
    logic          walk2_reg, walk2_next;
    logic [1:0]    status_reg, status_next;
    logic [VW-1:0] vout_reg, vout_next;
    logic [chme_pkg::BUCKETS-1:0] hvalid_reg, hvalid_next;

    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [SW-1:0] head_wdata, head_rdata;
    logic          link_we;
    logic [IW-1:0] link_waddr, link_raddr;
    logic [SW-1:0] link_wdata, link_rdata;
    logic          key_we;
    logic [IW-1:0] key_waddr, key_raddr;
    logic [KW-1:0] key_wdata, key_rdata;
    logic          val_we;
    logic [IW-1:0] val_waddr, val_raddr;
    logic [VW-1:0] val_wdata, val_rdata;

    logic [BW-1:0] cur_bkt;
    logic [SW-1:0] head_val;
    logic [KW-1:0] tkey;
    logic [SW-1:0] last;

    chme_ram #(.WIDTH(SW), .DEPTH(chme_pkg::BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    chme_ram #(.WIDTH(SW), .DEPTH(chme_pkg::CAPACITY)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );
    chme_ram #(.WIDTH(KW), .DEPTH(chme_pkg::CAPACITY)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );
    chme_ram #(.WIDTH(VW), .DEPTH(chme_pkg::CAPACITY)) u_val (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    assign cur_bkt  = walk2_reg ? lk_reg[BW-1:0] : key_reg[BW-1:0];
    assign head_val = hvalid_reg[cur_bkt] ? head_rdata : chme_pkg::NO_SLOT;
    assign tkey     = walk2_reg ? lk_reg : key_reg;
    assign last     = cnt_reg - SW'(1);

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = cnt_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        slot_next   = slot_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        head_next   = head_reg;
        hole_next   = hole_reg;
        lk_next     = lk_reg;
        lv_next     = lv_reg;
        walk2_next  = walk2_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        hvalid_next = hvalid_reg;

        head_we    = 1'b0;
        head_waddr = cur_bkt;
        head_wdata = slot_reg;
        head_raddr = cur_bkt;
        link_we    = 1'b0;
        link_waddr = prev_reg[IW-1:0];
        link_wdata = link_rdata;
        link_raddr = slot_reg[IW-1:0];
        key_we     = 1'b0;
        key_waddr  = slot_reg[IW-1:0];
        key_wdata  = key_reg;
        key_raddr  = slot_reg[IW-1:0];
        val_we     = 1'b0;
        val_waddr  = slot_reg[IW-1:0];
        val_wdata  = val_reg;
        val_raddr  = slot_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                head_raddr = key[BW-1:0];
                if (in_valid)
                begin
                    op_next     = op;
                    key_next    = key;
                    val_next    = value;
                    walk2_next  = 1'b0;
                    vout_next   = '0;
                    status_next = chme_pkg::ST_ABSENT;
                    state_next  = S_HEAD;
                end
            end
            S_HEAD:
            begin
                slot_next  = head_val;
                head_next  = head_val;
                prev_next  = chme_pkg::NO_SLOT;
                steps_next = '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (slot_reg < cnt_reg && steps_reg < CAP)
                begin
                    state_next = S_CMP;
                end
                else if (walk2_reg)
                begin
                    state_next = S_MV1;
                end
                else
                begin
                    state_next = S_OUT;
                    if (op_reg == chme_pkg::OP_INSERT)
                    begin
                        if (cnt_reg >= CAP)
                        begin
                            status_next = chme_pkg::ST_FULL;
                        end
                        else
                        begin
                            link_we     = 1'b1;
                            link_waddr  = cnt_reg[IW-1:0];
                            link_wdata  = head_reg;
                            head_we     = 1'b1;
                            head_wdata  = cnt_reg;
                            hvalid_next[cur_bkt] = 1'b1;
                            key_we      = 1'b1;
                            key_waddr   = cnt_reg[IW-1:0];
                            val_we      = 1'b1;
                            val_waddr   = cnt_reg[IW-1:0];
                            cnt_next    = cnt_reg + SW'(1);
                            status_next = chme_pkg::ST_NEW;
                        end
                    end
                end
            end
            S_CMP:
            begin
                if (key_rdata == tkey)
                begin
                    if (!walk2_reg)
                    begin
                        case (op_reg)
                            chme_pkg::OP_LOOKUP:
                            begin
                                status_next = chme_pkg::ST_HIT;
                                vout_next   = val_rdata;
                                state_next  = S_OUT;
                            end
                            chme_pkg::OP_INSERT:
                            begin
                                val_we      = 1'b1;
                                status_next = chme_pkg::ST_HIT;
                                state_next  = S_OUT;
                            end
                            chme_pkg::OP_ERASE:
                            begin
                                // unlink found entry
                                if (prev_reg < cnt_reg)
                                begin
                                    link_we = 1'b1;
                                end
                                else
                                begin
                                    head_we    = 1'b1;
                                    head_wdata = link_rdata;
                                    hvalid_next[cur_bkt] = 1'b1;
                                end
                                hole_next   = slot_reg;
                                status_next = chme_pkg::ST_HIT;
                                if (slot_reg != last)
                                begin
                                    key_raddr  = last[IW-1:0];
                                    state_next = S_LK;
                                end
                                else
                                begin
                                    cnt_next   = last;
                                    state_next = S_OUT;
                                end
                            end
                            default:
                            begin
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    else
                    begin
                        if (slot_reg == last)
                        begin
                            if (prev_reg < cnt_reg)
                            begin
                                link_we = 1'b1;
                            end
                            else
                            begin
                                head_we    = 1'b1;
                                head_wdata = link_rdata;
                                hvalid_next[cur_bkt] = 1'b1;
                            end
                        end
                        state_next = S_MV1;
                    end
                end
                else
                begin
                    prev_next  = slot_reg;
                    slot_next  = link_rdata;
                    steps_next = steps_reg + SW'(1);
                    state_next = S_CHK;
                end
            end
            S_LK:
            begin
                lk_next    = key_rdata;
                walk2_next = 1'b1;
                head_raddr = key_rdata[BW-1:0];
                val_raddr  = last[IW-1:0];
                state_next = S_LHEAD;
            end
            S_LHEAD:
            begin
                lv_next    = val_rdata;
                slot_next  = head_val;
                prev_next  = chme_pkg::NO_SLOT;
                steps_next = '0;
                state_next = S_CHK;
            end
            S_MV1:
            begin
                state_next = S_MV2;
            end
            S_MV2:
            begin
                // move last entry into the hole, link it at its bucket head
                key_we     = 1'b1;
                key_waddr  = hole_reg[IW-1:0];
                key_wdata  = lk_reg;
                val_we     = 1'b1;
                val_waddr  = hole_reg[IW-1:0];
                val_wdata  = lv_reg;
                link_we    = 1'b1;
                link_waddr = hole_reg[IW-1:0];
                link_wdata = head_val;
                head_we    = 1'b1;
                head_wdata = hole_reg;
                hvalid_next[cur_bkt] = 1'b1;
                cnt_next   = last;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    walk2_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            walk2_reg  <= 1'b0;
            hvalid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            walk2_reg  <= walk2_next;
            hvalid_reg <= hvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        head_reg   <= head_next;
        hole_reg   <= hole_next;
        lk_reg     <= lk_next;
        lv_reg     <= lv_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
    end

endmodule
